/* rtl/scr_pkg.sv */
// Shared types, constants and helpers for the sphere collision response block.
package scr_pkg;

  // Contact class, decided at the front from the two masses
  localparam logic [1:0] MODE_SELF_INF  = 2'd0;
  localparam logic [1:0] MODE_OTHER_INF = 2'd1;
  localparam logic [1:0] MODE_FINITE    = 2'd2;

  localparam int SQRT_STEPS    = 32;  // root bits of a 64-bit sum of squares
  localparam int GAP_W         = 33;
  localparam int A_W           = 36;  // rescaled dot product
  localparam int DIFF_W        = 38;  // doubled dot product difference
  localparam int IMP_W         = 40;  // rescaled impulse
  localparam int G_W           = 35;  // gap share
  localparam int SAT_W         = 43;
  localparam int IMPULSE_SHIFT = 1;   // elastic impulse factor of two

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic signed [SAT_W-1:0] SAT_HI = 43'sh000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = -43'sh000_8000_0000;

  // Contact handed from the front to the back, minus normal and mass share
  typedef struct packed {
    logic [1:0]           mode;
    logic [GAP_W-1:0]     gap;
    logic [2:0][31:0]     v1;
    logic [2:0][31:0]     v2;
  } contact_t;

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [32:0] t, input logic [31:0] dvsr);
    logic        ge;
    logic [32:0] r;
    ge = (t >= {1'b0, dvsr});
    r  = ge ? (t - {1'b0, dvsr}) : t;
    return {ge, r[31:0]};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [31:0] r;
    if (x > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/scr_fifo.sv */
// Small register queue with first-word fall-through read.
module scr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

/* rtl/scr_front.sv */
// Front pipeline: classify, length by square root, unit normal and mass share by division.
module scr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2:0][31:0]             disp,
  input  logic [2:0][31:0]             vel1,
  input  logic [2:0][31:0]             vel2,
  input  logic [30:0]                  rsum,
  input  logic [30:0]                  m1,
  input  logic [30:0]                  m2,
  output logic                         out_valid,
  output scr_pkg::contact_t            out_ct,
  output logic [2:0][FRAC_BITS+1:0]    out_n,
  output logic [FRAC_BITS:0]           out_share
);
  import scr_pkg::*;

  localparam int NW   = FRAC_BITS + 2;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NDIV = FRAC_BITS + 1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [30:0]      rsum;
    logic [30:0]      m2;
    logic [31:0]      msum;
    logic [2:0][31:0] v1;
    logic [2:0][31:0] v2;
  } fcarry_t;

  // classify and take magnitudes
  fcarry_t c0_nxt, c0_r, c1_r, c2_r;
  logic    v0_r, v1_r, v2_r;
  logic [63:0] sqa_r [3];
  logic [63:0] sq_r;

  always_comb begin
    c0_nxt = '0;
    priority if (m1 == '0) begin
      c0_nxt.mode = MODE_SELF_INF;
    end else if (m2 == '0) begin
      c0_nxt.mode = MODE_OTHER_INF;
    end else begin
      c0_nxt.mode = MODE_FINITE;
    end
    for (int i = 0; i < 3; i++) begin
      c0_nxt.neg[i] = disp[i][31];
      c0_nxt.mag[i] = disp[i][31] ? (~disp[i] + 32'd1) : disp[i];
    end
    c0_nxt.rsum = rsum;
    c0_nxt.m2   = m2;
    c0_nxt.msum = {1'b0, m1} + {1'b0, m2};
    c0_nxt.v1   = vel1;
    c0_nxt.v2   = vel2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
      c1_r <= c0_r;
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        sqa_r[i] <= 64'(c0_r.mag[i]) * 64'(c0_r.mag[i]);
      end
      sq_r <= sqa_r[0] + sqa_r[1] + sqa_r[2];
    end
  end

  // square root, one root bit per stage
  logic [32:0] s_rem  [1:SQRT_STEPS];
  logic [31:0] s_root [1:SQRT_STEPS];
  logic [63:0] s_bits [1:SQRT_STEPS];
  fcarry_t     s_c    [1:SQRT_STEPS];
  logic        s_v    [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] bits_in;
    fcarry_t     c_in;
    logic        v_in;
    logic [34:0] remb, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign bits_in = sq_r;
      assign c_in    = c2_r;
      assign v_in    = v2_r;
    end else begin : g_next
      assign rem_in  = s_rem[k];
      assign root_in = s_root[k];
      assign bits_in = s_bits[k];
      assign c_in    = s_c[k];
      assign v_in    = s_v[k];
    end

    assign remb  = {rem_in, bits_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (remb >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_v[k+1] <= 1'b0;
      end else if (en) begin
        s_v[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[k+1]  <= ge ? 33'(remb - trial) : remb[32:0];
        s_root[k+1] <= {root_in[30:0], ge};
        s_bits[k+1] <= {bits_in[61:0], 2'b00};
        s_c[k+1]    <= c_in;
      end
    end
  end

  // three normal lanes divide by the length, lane 3 divides m2 by the mass sum
  logic [31:0]       dv_rem [0:3][1:NDIV];
  logic [QW-1:0]     dv_q   [0:3][1:NDIV];
  logic [31:0]       d_len  [1:NDIV];
  logic [GAP_W-1:0]  d_gap  [1:NDIV];
  fcarry_t           d_c    [1:NDIV];
  logic              d_v    [1:NDIV];

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [31:0]      len_in;
    logic [GAP_W-1:0] gap_in;
    fcarry_t          c_in;
    logic             v_in;

    if (j == 0) begin : g_first
      assign len_in = s_root[SQRT_STEPS];
      assign c_in   = s_c[SQRT_STEPS];
      assign v_in   = s_v[SQRT_STEPS];
      assign gap_in = {1'b0, s_root[SQRT_STEPS]} - {2'b00, s_c[SQRT_STEPS].rsum};
    end else begin : g_next
      assign len_in = d_len[j];
      assign c_in   = d_c[j];
      assign v_in   = d_v[j];
      assign gap_in = d_gap[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v[j+1] <= 1'b0;
      end else if (en) begin
        d_v[j+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_len[j+1] <= len_in;
        d_gap[j+1] <= gap_in;
        d_c[j+1]   <= c_in;
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [31:0]   rem_in, dvsr;
      logic [QW-1:0] q_in;
      logic [32:0]   t, r;

      if (j == 0) begin : g_seed
        if (l < 3) begin : g_norm
          assign rem_in = c_in.mag[l];
        end else begin : g_share
          assign rem_in = {1'b0, c_in.m2};
        end
        assign q_in = '0;
      end else begin : g_carry
        assign rem_in = dv_rem[l][j];
        assign q_in   = dv_q[l][j];
      end

      if (l < 3) begin : g_dl
        assign dvsr = len_in;
      end else begin : g_dm
        assign dvsr = c_in.msum;
      end

      // first step tests the dividend as is, later steps shift in a zero
      if (j == 0) begin : g_t0
        assign t = {1'b0, rem_in};
      end else begin : g_tn
        assign t = {rem_in, 1'b0};
      end

      assign r = div_step(t, dvsr);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[l][j+1] <= r[31:0];
          dv_q[l][j+1]   <= {q_in[QW-2:0], r[32]};
        end
      end
    end
  end

  // apply signs, zero the normal for a zero-length displacement
  logic [2:0][NW-1:0] n_nxt;
  contact_t           ct_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_len[NDIV] == '0) begin
        n_nxt[i] = '0;
      end else if (d_c[NDIV].neg[i]) begin
        n_nxt[i] = ~{1'b0, dv_q[i][NDIV]} + 1'b1;
      end else begin
        n_nxt[i] = {1'b0, dv_q[i][NDIV]};
      end
    end
    ct_nxt.mode = d_c[NDIV].mode;
    ct_nxt.gap  = d_gap[NDIV];
    ct_nxt.v1   = d_c[NDIV].v1;
    ct_nxt.v2   = d_c[NDIV].v2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ct    <= ct_nxt;
      out_n     <= n_nxt;
      out_share <= dv_q[3][NDIV];
    end
  end
endmodule

/* rtl/scr_back.sv */
// Back pipeline: dot products, impulse, gap share, scaling and saturation.
module scr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  scr_pkg::contact_t         in_ct,
  input  logic [2:0][FRAC_BITS+1:0] in_n,
  input  logic [FRAC_BITS:0]        in_share,
  output logic                      out_valid,
  output logic [2:0][31:0]          out_vel,
  output logic [2:0][31:0]          out_off
);
  import scr_pkg::*;

  localparam int NW = FRAC_BITS + 2;
  localparam int PW = NW + 32;
  localparam int SW = NW + 34;
  localparam int GSW = GAP_W + NW;
  localparam int IPW = DIFF_W + NW;
  localparam int QVW = IMP_W + NW;
  localparam int OVW = G_W + NW;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0][NW-1:0] n;
    logic [2:0][31:0]   v1;
    logic [FRAC_BITS:0] share;
  } bcarry_t;

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  bcarry_t bc0_nxt, bc0_r, bc1_r, bc2_r, bc3_r, bc4_r;

  // stage 0: products along the normal, gap times share
  logic signed [PW-1:0]    p1_nxt [3], p2_nxt [3], p1_r [3], p2_r [3];
  logic signed [GSW-1:0]   gs_nxt, gs_r;
  logic signed [GAP_W-1:0] gap0_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_nxt[i] = $signed(in_n[i]) * $signed(in_ct.v1[i]);
      p2_nxt[i] = $signed(in_n[i]) * $signed(in_ct.v2[i]);
    end
    gs_nxt        = $signed(in_ct.gap) * $signed({1'b0, in_share});
    bc0_nxt.mode  = in_ct.mode;
    bc0_nxt.n     = in_n;
    bc0_nxt.v1    = in_ct.v1;
    bc0_nxt.share = in_share;
  end

  // stage 1: rescale dot products, pick the gap share
  logic signed [SW-1:0]  s1, s2;
  logic signed [GSW-1:0] gsh;
  logic signed [A_W-1:0] a1_nxt, a2_nxt, a1_r, a2_r;
  logic signed [G_W-1:0] g1_nxt, g1_r, g2_r, g3_r;

  always_comb begin
    s1     = p1_r[0] + p1_r[1] + p1_r[2];
    s2     = p2_r[0] + p2_r[1] + p2_r[2];
    a1_nxt = A_W'(s1 >>> FRAC_BITS);
    a2_nxt = A_W'(s2 >>> FRAC_BITS);
    gsh    = gs_r >>> FRAC_BITS;
    // against an immovable body the whole gap goes to self
    g1_nxt = (bc0_r.mode == MODE_FINITE) ? G_W'(gsh) : G_W'(gap0_r);
  end

  // stage 2: doubled difference, stage 3: times share
  logic signed [DIFF_W-1:0] diff2_nxt, diff2_r;
  logic signed [IPW-1:0]    ip_nxt, ip_r;

  always_comb begin
    diff2_nxt = (DIFF_W'(a2_r) - DIFF_W'(a1_r)) <<< IMPULSE_SHIFT;
    ip_nxt    = diff2_r * $signed({1'b0, bc2_r.share});
  end

  // stage 4: scale the normal by impulse and by gap share
  logic signed [IMP_W-1:0] imp;
  logic signed [QVW-1:0]   qv_nxt [3], qv_r [3];
  logic signed [OVW-1:0]   ov_nxt [3], ov_r [3];

  always_comb begin
    imp = IMP_W'(ip_r >>> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      qv_nxt[i] = imp * $signed(bc3_r.n[i]);
      ov_nxt[i] = g3_r * $signed(bc3_r.n[i]);
    end
  end

  // stage 5: add, select by contact class, saturate
  logic [2:0][31:0] vel_nxt, off_nxt;

  always_comb begin
    logic signed [31:0]      v1s;
    logic signed [SAT_W-1:0] tv, tn, to;
    for (int i = 0; i < 3; i++) begin
      v1s = $signed(bc4_r.v1[i]);
      tv  = SAT_W'(v1s) + SAT_W'(qv_r[i] >>> FRAC_BITS);
      tn  = -SAT_W'(v1s);
      to  = SAT_W'(ov_r[i] >>> FRAC_BITS);
      unique case (bc4_r.mode)
        MODE_OTHER_INF: begin
          vel_nxt[i] = sat32(tn);
          off_nxt[i] = sat32(to);
        end
        MODE_FINITE: begin
          vel_nxt[i] = sat32(tv);
          off_nxt[i] = sat32(to);
        end
        default: begin
          vel_nxt[i] = bc4_r.v1[i];
          off_nxt[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0_r      <= in_valid;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      out_valid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= p1_nxt[i];
        p2_r[i] <= p2_nxt[i];
        qv_r[i] <= qv_nxt[i];
        ov_r[i] <= ov_nxt[i];
      end
      gs_r    <= gs_nxt;
      gap0_r  <= $signed(in_ct.gap);
      bc0_r   <= bc0_nxt;
      a1_r    <= a1_nxt;
      a2_r    <= a2_nxt;
      g1_r    <= g1_nxt;
      bc1_r   <= bc0_r;
      diff2_r <= diff2_nxt;
      g2_r    <= g1_r;
      bc2_r   <= bc1_r;
      ip_r    <= ip_nxt;
      g3_r    <= g2_r;
      bc3_r   <= bc2_r;
      bc4_r   <= bc3_r;
      out_vel <= vel_nxt;
      out_off <= off_nxt;
    end
  end
endmodule

/* rtl/sphere_collision_response.sv */
// Sphere collision response: takes one sphere pair per clock and returns the self sphere's
// resolved velocity and position offset in signed fixed point with FRAC_BITS fraction bits.
// A new pair is accepted every cycle while full is low. A pair's result passes through the
// 32-stage square root for the contact length and the FRAC_BITS + 1 stage divider for the
// unit normal and mass share. A queue between the front (length, normal) and back (impulse,
// offset) pipelines and a result queue let either side stall independently. A mass of zero
// means an immovable body.
module sphere_collision_response #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_disp_x,
  input  logic [31:0] in_disp_y,
  input  logic [31:0] in_disp_z,
  input  logic [31:0] in_self_vel_x,
  input  logic [31:0] in_self_vel_y,
  input  logic [31:0] in_self_vel_z,
  input  logic [31:0] in_other_vel_x,
  input  logic [31:0] in_other_vel_y,
  input  logic [31:0] in_other_vel_z,
  input  logic [30:0] in_radius_sum,
  input  logic [30:0] in_self_mass,
  input  logic [30:0] in_other_mass,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic [31:0] out_new_vel_z,
  output logic [31:0] out_offset_x,
  output logic [31:0] out_offset_y,
  output logic [31:0] out_offset_z
);
  import scr_pkg::*;

  localparam int NW    = FRAC_BITS + 2;
  localparam int MID_W = $bits(contact_t) + 3 * NW + FRAC_BITS + 1;
  localparam int OUT_W = 6 * 32;

  logic fen, ben;
  logic mid_full, mid_empty, out_full;

  logic                   f_valid;
  contact_t               f_ct;
  logic [2:0][NW-1:0]     f_n;
  logic [FRAC_BITS:0]     f_share;

  contact_t               m_ct;
  logic [2:0][NW-1:0]     m_n;
  logic [FRAC_BITS:0]     m_share;
  logic [MID_W-1:0]       mid_rdata;

  logic                   b_valid;
  logic [2:0][31:0]       b_vel, b_off;
  logic [OUT_W-1:0]       out_rdata;

  // hold the front while the middle queue is full, the back while results back up
  assign fen  = !mid_full;
  assign ben  = !out_full;
  assign full = mid_full;

  scr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fen),
    .in_valid  (push),
    .disp      ({in_disp_z, in_disp_y, in_disp_x}),
    .vel1      ({in_self_vel_z, in_self_vel_y, in_self_vel_x}),
    .vel2      ({in_other_vel_z, in_other_vel_y, in_other_vel_x}),
    .rsum      (in_radius_sum),
    .m1        (in_self_mass),
    .m2        (in_other_mass),
    .out_valid (f_valid),
    .out_ct    (f_ct),
    .out_n     (f_n),
    .out_share (f_share)
  );

  scr_fifo #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid && fen),
    .wdata ({f_ct, f_n, f_share}),
    .pop   (ben && !mid_empty),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign {m_ct, m_n, m_share} = mid_rdata;

  scr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (ben),
    .in_valid  (!mid_empty),
    .in_ct     (m_ct),
    .in_n      (m_n),
    .in_share  (m_share),
    .out_valid (b_valid),
    .out_vel   (b_vel),
    .out_off   (b_off)
  );

  scr_fifo #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (b_valid && ben),
    .wdata ({b_vel, b_off}),
    .pop   (pop && !empty),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (empty)
  );

  assign {out_new_vel_z, out_new_vel_y, out_new_vel_x,
          out_offset_z, out_offset_y, out_offset_x} = out_rdata;
endmodule

/* rtl/scr_checker.sv */
// Port-level checks for the sphere collision response block, bound to the top level.
module scr_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [31:0] out_new_vel_x,
  input logic [31:0] out_new_vel_y,
  input logic [31:0] out_new_vel_z,
  input logic [31:0] out_offset_x,
  input logic [31:0] out_offset_y,
  input logic [31:0] out_offset_z
);
  import scr_pkg::*;

  // beats accepted but not yet delivered
  logic [7:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_new_vel_x) && $stable(out_new_vel_y) &&
      $stable(out_new_vel_z) && $stable(out_offset_x) && $stable(out_offset_y) &&
      $stable(out_offset_z)))
    else $error("waiting result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (cnt_r != 8'd0))
    else $error("result shown with no beat outstanding");

  a_full_backed: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (cnt_r >= 8'(MID_DEPTH)))
    else $error("full raised with too few beats in flight");
endmodule

bind sphere_collision_response scr_port_checker u_scr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .out_new_vel_x (out_new_vel_x),
  .out_new_vel_y (out_new_vel_y),
  .out_new_vel_z (out_new_vel_z),
  .out_offset_x  (out_offset_x),
  .out_offset_y  (out_offset_y),
  .out_offset_z  (out_offset_z)
);

/* bench/scr_checker.sv */
// Checker for the sphere collision response block: predicts each result and compares it.
module scr_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] in_disp_x,
  input  logic [31:0] in_disp_y,
  input  logic [31:0] in_disp_z,
  input  logic [31:0] in_self_vel_x,
  input  logic [31:0] in_self_vel_y,
  input  logic [31:0] in_self_vel_z,
  input  logic [31:0] in_other_vel_x,
  input  logic [31:0] in_other_vel_y,
  input  logic [31:0] in_other_vel_z,
  input  logic [30:0] in_radius_sum,
  input  logic [30:0] in_self_mass,
  input  logic [30:0] in_other_mass,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] out_new_vel_x,
  input  logic [31:0] out_new_vel_y,
  input  logic [31:0] out_new_vel_z,
  input  logic [31:0] out_offset_x,
  input  logic [31:0] out_offset_y,
  input  logic [31:0] out_offset_z,
  output int          fail_count,
  output int          pending,
  output int          beats_in,
  output int          beats_out
);

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0][31:0] off;
  } response_t;

  response_t response_q[$];

  function automatic longint floor_rescale(input longint x);
    return x >>> FRAC_BITS;  // arithmetic shift floors
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic longint int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic response_t resolve_contact(
    input logic [2:0][31:0] dv, input logic [2:0][31:0] v1v,
    input logic [2:0][31:0] v2v, input logic [30:0] rsum,
    input logic [30:0] m1, input logic [30:0] m2);
    response_t res;
    longint d[3], v1[3], v2[3], n[3], nv[3], of[3];
    longint unsigned sq;
    longint len, gap, a1, a2, share, imp, g;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = longint'(signed'(dv[i]));
      v1[i] = longint'(signed'(v1v[i]));
      v2[i] = longint'(signed'(v2v[i]));
    end
    if (m1 == 0) begin
      for (int i = 0; i < 3; i++) begin
        nv[i] = v1[i];
        of[i] = 0;
      end
    end else begin
      for (int i = 0; i < 3; i++) sq += longint'(d[i] * d[i]);
      len = int_root(sq);
      gap = len - longint'(rsum);
      for (int i = 0; i < 3; i++) n[i] = (len == 0) ? 0 : (d[i] <<< FRAC_BITS) / len;
      if (m2 == 0) begin
        for (int i = 0; i < 3; i++) begin
          nv[i] = -v1[i];
          of[i] = floor_rescale(gap * n[i]);
        end
      end else begin
        a1 = 0;
        a2 = 0;
        for (int i = 0; i < 3; i++) begin
          a1 += n[i] * v1[i];
          a2 += n[i] * v2[i];
        end
        a1 = floor_rescale(a1);
        a2 = floor_rescale(a2);
        share = (longint'(m2) <<< FRAC_BITS) / (longint'(m1) + longint'(m2));
        imp = floor_rescale(2 * (a2 - a1) * share);
        g = floor_rescale(gap * share);
        for (int i = 0; i < 3; i++) begin
          nv[i] = v1[i] + floor_rescale(imp * n[i]);
          of[i] = floor_rescale(g * n[i]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.vel[i] = clamp32(nv[i]);
      res.off[i] = clamp32(of[i]);
    end
    return res;
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    beats_in = 0;
    beats_out = 0;
  end

  assign pending = response_q.size();

  always @(posedge clk) begin
    response_t want;
    if (rst_n && push && !full) begin
      response_q.push_back(resolve_contact(
        {in_disp_z, in_disp_y, in_disp_x},
        {in_self_vel_z, in_self_vel_y, in_self_vel_x},
        {in_other_vel_z, in_other_vel_y, in_other_vel_x},
        in_radius_sum, in_self_mass, in_other_mass));
      beats_in++;
    end
    if (rst_n && pop && !empty) begin
      beats_out++;
      if (response_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = response_q.pop_front();
        compare("new_vel_x", want.vel[0], out_new_vel_x);
        compare("new_vel_y", want.vel[1], out_new_vel_y);
        compare("new_vel_z", want.vel[2], out_new_vel_z);
        compare("offset_x", want.off[0], out_offset_x);
        compare("offset_y", want.off[1], out_offset_y);
        compare("offset_z", want.off[2], out_offset_z);
      end
    end
  end

endmodule

/* bench/tb_sphere_collision_response.sv */
// Testbench top for the sphere collision response block: stimulus, stalls and verdict.
module tb_sphere_collision_response;

  localparam int FRAC_BITS = 16;
  localparam int N_RANDOM  = 800;
  localparam int IDLE_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [31:0] disp_x = '0, disp_y = '0, disp_z = '0;
  logic [31:0] sv_x = '0, sv_y = '0, sv_z = '0;
  logic [31:0] ov_x = '0, ov_y = '0, ov_z = '0;
  logic [30:0] rsum = '0, m_self = '0, m_other = '0;
  logic [31:0] nv_x, nv_y, nv_z, off_x, off_y, off_z;
  int          fail_count, pending, beats_in, beats_out;
  int          idle_cycles = 0;
  bit          feeding_done = 1'b0;
  bit          hold_done = 1'b0;

  always #5 clk = ~clk;

  sphere_collision_response #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk, .rst_n, .push, .full,
    .in_disp_x(disp_x), .in_disp_y(disp_y), .in_disp_z(disp_z),
    .in_self_vel_x(sv_x), .in_self_vel_y(sv_y), .in_self_vel_z(sv_z),
    .in_other_vel_x(ov_x), .in_other_vel_y(ov_y), .in_other_vel_z(ov_z),
    .in_radius_sum(rsum), .in_self_mass(m_self), .in_other_mass(m_other),
    .empty, .pop,
    .out_new_vel_x(nv_x), .out_new_vel_y(nv_y), .out_new_vel_z(nv_z),
    .out_offset_x(off_x), .out_offset_y(off_y), .out_offset_z(off_z)
  );

  scr_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
    .clk, .rst_n, .push, .full,
    .in_disp_x(disp_x), .in_disp_y(disp_y), .in_disp_z(disp_z),
    .in_self_vel_x(sv_x), .in_self_vel_y(sv_y), .in_self_vel_z(sv_z),
    .in_other_vel_x(ov_x), .in_other_vel_y(ov_y), .in_other_vel_z(ov_z),
    .in_radius_sum(rsum), .in_self_mass(m_self), .in_other_mass(m_other),
    .empty, .pop,
    .out_new_vel_x(nv_x), .out_new_vel_y(nv_y), .out_new_vel_z(nv_z),
    .out_offset_x(off_x), .out_offset_y(off_y), .out_offset_z(off_z),
    .fail_count, .pending, .beats_in, .beats_out
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mostly moderate values so the math stays in range, with full-range noise mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
      2: return 32'($urandom_range(0, 1) ? 0 : -1);
      default: return 32'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      3: return 31'd1;
      default: return 31'($urandom_range(1, 32'h00FF_FFFF));
    endcase
  endfunction

  task automatic send_pair(input logic [31:0] dx, dy, dz, s1, s2, s3, o1, o2, o3,
                           input logic [30:0] rs, ms, mo);
    push   <= 1'b1;
    disp_x <= dx; disp_y <= dy; disp_z <= dz;
    sv_x <= s1; sv_y <= s2; sv_z <= s3;
    ov_x <= o1; ov_y <= o2; ov_z <= o3;
    rsum <= rs; m_self <= ms; m_other <= mo;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_random();
    int idle;
    send_pair(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(),
              $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h00FF_FFFF)),
              rand_mass(), rand_mass());
    idle = (hold_done && $urandom_range(0, 3) != 0) ? gap_len() : 0;
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Sender: directed corners first, then random pairs.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // self infinite, also with the other infinite
    send_pair(32'h0001_0000, 0, 0, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              0, 0, 0, 31'h0001_0000, 0, 31'h0001_0000);
    send_pair(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 0, 0);
    // other infinite: negating the most negative velocity saturates
    send_pair(32'h0003_0000, 32'h0004_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
              0, 0, 0, 31'h0002_0000, 31'h0001_0000, 0);
    // zero displacement with the other infinite and with finite masses
    send_pair(0, 0, 0, 32'h0005_0000, 32'hFFFF_0000, 0, 32'h0100_0000, 0, 0,
              31'h0001_0000, 31'h0001_0000, 0);
    send_pair(0, 0, 0, 32'h0005_0000, 32'hFFFF_0000, 0, 32'h0100_0000, 0, 0,
              31'h0001_0000, 31'h0001_0000, 31'h0003_0000);
    // head-on equal masses, overlapping
    send_pair(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 0, 0,
              31'h0002_0000, 31'h0001_0000, 31'h0001_0000);
    // extremes of every field
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              0, 31'd1, 31'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1);
    send_pair(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 31'h7FFF_FFFF,
              31'd1, 0);
    // random pairs; the first stretch runs back to back while the receiver holds off
    for (int k = 0; k < N_RANDOM; k++) send_random();
    push <= 1'b0;
    feeding_done = 1'b1;
  end

  // Receiver: a long hold-off first so the block fills, then random stalls.
  initial begin
    int stall;
    @(posedge rst_n);
    repeat (400) @(posedge clk);
    hold_done = 1'b1;
    forever begin
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (stall > 0) begin
          pop <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles without a beat on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !hold_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    wait (feeding_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d contacts across all mass classes, corners and saturation cases;",
             beats_in);
    $display("checked %0d resolved velocities and offsets under random stalls.", beats_out);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
